@@ rtl/core/laser_aim_angle_from_range_assert.svh @@
// Assertion macros shared by the checker files of the laser aim block.
// Holds nothing but macro definitions under an include guard.
`ifndef LASER_AIM_ANGLE_FROM_RANGE_ASSERT_SVH
`define LASER_AIM_ANGLE_FROM_RANGE_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define LAAR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication whose consequence is checked in the following cycle.
`define LAAR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/core/laar_pkg.sv @@
// Shared types and constants of the laser aim angle block.
// Depends on nothing; used by the top level, laar_atan2 and laar_cordic_cell.
package laar_pkg;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_POINT_X = 3'd0;
  localparam logic [2:0] REG_POINT_Y = 3'd1;
  localparam logic [2:0] REG_POINT_Z = 3'd2;
  localparam logic [2:0] REG_DIR_X   = 3'd3;
  localparam logic [2:0] REG_DIR_Y   = 3'd4;
  localparam logic [2:0] REG_DIR_Z   = 3'd5;

  // Reset values of the laser line registers.
  localparam logic [31:0] RST_POINT_X = 32'sd2255664;
  localparam logic [31:0] RST_POINT_Y = 32'sd909217;
  localparam logic [31:0] RST_POINT_Z = 32'sd0;
  localparam logic [31:0] RST_DIR_X   = -32'sd18967279;
  localparam logic [31:0] RST_DIR_Y   = 32'sd7143657;
  localparam logic [31:0] RST_DIR_Z   = -32'sd1073550516;

  // Width of the CORDIC vector and angle datapath.
  localparam int VW = 44;
  localparam int AW = 34;

  // Pi in Q.30, signed angle width.
  localparam logic signed [AW-1:0] PI_Q30 = 34'sd3373259426;
  localparam logic signed [VW-1:0] NORM_LIMIT = 44'sd137438953472;

  // One CORDIC vector with its accumulated angle.
  typedef struct packed {
    logic signed [VW-1:0] vx;
    logic signed [VW-1:0] vy;
    logic signed [AW-1:0] ang;
  } cvec_t;

  // Arctangent table in Q.30, truncated values.
  function automatic logic signed [AW-1:0] atan_q30(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;
      5'd29: v = 32'h00000002;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return AW'(signed'({1'b0, v}));
  endfunction

endpackage

@@ rtl/core/laar_cordic_cell.sv @@
// One CORDIC vectoring cell: a single micro-rotation with a register after it.
// Depends on laar_pkg for the vector type and the arctangent table.
module laar_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  laar_pkg::cvec_t vec_i,
  output laar_pkg::cvec_t vec_o
);

  laar_pkg::cvec_t vec_d, vec_q;

  // Rotate toward the x axis by atan(2^-STEP).
  always_comb begin
    if (vec_i.vy >= 0) begin
      vec_d.vx  = vec_i.vx + (vec_i.vy >>> STEP);
      vec_d.vy  = vec_i.vy - (vec_i.vx >>> STEP);
      vec_d.ang = vec_i.ang + laar_pkg::atan_q30(5'(STEP));
    end else begin
      vec_d.vx  = vec_i.vx - (vec_i.vy >>> STEP);
      vec_d.vy  = vec_i.vy + (vec_i.vx >>> STEP);
      vec_d.ang = vec_i.ang - laar_pkg::atan_q30(5'(STEP));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec_q <= vec_d;
    end
  end

  assign vec_o = vec_q;

endmodule

@@ rtl/core/laar_atan2.sv @@
// Pipelined atan2: normalize, fold into the right half plane, then a chain of
// CORDIC cells and a combinational rounding step. Depends on laar_pkg, laar_cordic_cell.
module laar_atan2 #(
  parameter int STEPS = 24
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [39:0] z_i,
  input  logic signed [39:0] s_i,
  output logic signed [31:0] ang_o
);

  localparam int VW = laar_pkg::VW;
  localparam int AW = laar_pkg::AW;

  // Normalization shift: doubling until a part reaches 2^37.
  logic [5:0]           sh;
  logic signed [VW-1:0] zx, sx;
  logic [VW-1:0]        orv;
  always_comb begin
    zx  = VW'(z_i);
    sx  = VW'(s_i);
    orv = (zx < 0 ? ~zx : zx) | (sx < 0 ? ~sx : sx);
    // Magnitude below 2^37 means abs bits above 36 clear; ~v for negatives
    // gives abs-1, so compare on the magnitude directly below.
    sh = 6'd0;
    for (int k = 0; k < 38; k++) begin
      if ((((zx < 0 ? -zx : zx) | (sx < 0 ? -sx : sx)) <<< k) <
          (laar_pkg::NORM_LIMIT) && sh == 6'(k)) begin
        sh = 6'(k + 1);
      end
    end
  end

  // Stage 1: registered normalized vector with start angle.
  laar_pkg::cvec_t v0_d, v0_q;
  logic            zero_d;
  logic signed [VW-1:0] nz, ns;
  always_comb begin
    zero_d = (z_i == 0) && (s_i == 0);
    nz = zx <<< sh;
    ns = sx <<< sh;
    if (orv == '0 && zero_d) begin
      nz = '0;
    end
    if (nz < 0) begin
      v0_d.vx  = -nz;
      v0_d.vy  = -ns;
      v0_d.ang = (ns >= 0) ? laar_pkg::PI_Q30 : -laar_pkg::PI_Q30;
    end else begin
      v0_d.vx  = nz;
      v0_d.vy  = ns;
      v0_d.ang = '0;
    end
  end

  logic zero_q [STEPS+1];
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v0_q      <= v0_d;
      zero_q[0] <= zero_d;
      for (int k = 1; k <= STEPS; k++) begin
        zero_q[k] <= zero_q[k-1];
      end
    end
  end

  // Chain of micro-rotation cells.
  laar_pkg::cvec_t chain [STEPS+1];
  assign chain[0] = v0_q;
  for (genvar g = 0; g < STEPS; g++) begin : g_cell
    laar_cordic_cell #(.STEP(g)) u_cell (
      .clk_i (clk_i),
      .en_i  (en_i),
      .vec_i (chain[g]),
      .vec_o (chain[g+1])
    );
  end

  // Round Q.30 to Q.28 and force zero for a zero vector.
  logic signed [AW-1:0] rnd;
  assign rnd   = (chain[STEPS].ang + AW'(2)) >>> 2;
  assign ang_o = zero_q[STEPS] ? 32'sd0 : 32'(rnd);

endmodule

@@ rtl/core/laar_project.sv @@
// Projection of (0,0,range) onto the laser line in three registered stages.
// Depends on nothing but plain arithmetic.
module laar_project (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [31:0]        range_i,
  input  logic signed [31:0] px_i,
  input  logic signed [31:0] py_i,
  input  logic signed [31:0] pz_i,
  input  logic signed [31:0] dx_i,
  input  logic signed [31:0] dy_i,
  input  logic signed [31:0] dz_i,
  output logic signed [39:0] cx_o,
  output logic signed [39:0] cy_o,
  output logic signed [39:0] cz_o
);

  // Stage 1: the three products of the dot product.
  logic signed [33:0] vz;
  logic signed [65:0] mx_q, my_q, mz_q;
  assign vz = 34'(signed'({1'b0, range_i})) - 34'(pz_i);
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mx_q <= 66'(-34'(px_i)) * 66'(dx_i);
      my_q <= 66'(-34'(py_i)) * 66'(dy_i);
      mz_q <= 66'(vz) * 66'(dz_i);
    end
  end

  // Stage 2: sum and shift gives t.
  logic signed [67:0] sum;
  logic signed [37:0] t_q;
  assign sum = 68'(mx_q) + 68'(my_q) + 68'(mz_q);
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q <= 38'(sum >>> 30);
    end
  end

  // Stage 3: closest point per axis.
  logic signed [69:0] tx, ty, tz;
  assign tx = 70'(t_q) * 70'(dx_i);
  assign ty = 70'(t_q) * 70'(dy_i);
  assign tz = 70'(t_q) * 70'(dz_i);
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cx_o <= 40'(px_i) + 40'(tx >>> 30);
      cy_o <= 40'(py_i) + 40'(ty >>> 30);
      cz_o <= 40'(pz_i) + 40'(tz >>> 30);
    end
  end

endmodule

@@ rtl/core/laser_aim_angle_from_range.sv @@
// Laser aim angles from a measured range: projection onto the laser line
// followed by two CORDIC atan2 chains. The pipeline has three projection
// stages, one normalize stage, the chain of CORDIC cells and the output
// register. Throughput one transfer per cycle; the whole pipeline
// advances when the output register is free or being taken.
// Reset clears valid bits and loads the laser line reset values.
module laser_aim_angle_from_range #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,  // range_mm, yaw_now, pitch_now
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [183:0] m_axis_tdata,  // yaw_goal, pitch_goal, near_x, near_y, near_z
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i
);

  localparam int LAT = CORDIC_STEPS + 5;

  // Configuration registers.
  logic [31:0] px_q, py_q, pz_q, dx_q, dy_q, dz_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q <= laar_pkg::RST_POINT_X;
      py_q <= laar_pkg::RST_POINT_Y;
      pz_q <= laar_pkg::RST_POINT_Z;
      dx_q <= laar_pkg::RST_DIR_X;
      dy_q <= laar_pkg::RST_DIR_Y;
      dz_q <= laar_pkg::RST_DIR_Z;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        laar_pkg::REG_POINT_X: px_q <= cfg_data_i;
        laar_pkg::REG_POINT_Y: py_q <= cfg_data_i;
        laar_pkg::REG_POINT_Z: pz_q <= cfg_data_i;
        laar_pkg::REG_DIR_X:   dx_q <= cfg_data_i;
        laar_pkg::REG_DIR_Y:   dy_q <= cfg_data_i;
        laar_pkg::REG_DIR_Z:   dz_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline advance: stalls only when the last stage holds an untaken result.
  logic en;
  logic [LAT-1:0] vld_q;
  assign en            = !vld_q[LAT-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
    end
  end

  // Current angles travel alongside the datapath.
  logic [31:0] yaw_q [LAT-1];
  logic [31:0] pit_q [LAT-1];
  always_ff @(posedge clk_i) begin
    if (en) begin
      yaw_q[0] <= s_axis_tdata[63:32];
      pit_q[0] <= s_axis_tdata[95:64];
      for (int k = 1; k < LAT-1; k++) begin
        yaw_q[k] <= yaw_q[k-1];
        pit_q[k] <= pit_q[k-1];
      end
    end
  end

  logic signed [39:0] cx, cy, cz;
  laar_project u_proj (
    .clk_i   (clk_i),
    .en_i    (en),
    .range_i (s_axis_tdata[31:0]),
    .px_i    (px_q), .py_i (py_q), .pz_i (pz_q),
    .dx_i    (dx_q), .dy_i (dy_q), .dz_i (dz_q),
    .cx_o    (cx), .cy_o (cy), .cz_o (cz)
  );

  // Closest point delayed to match the CORDIC chain.
  logic [119:0] pt_q [CORDIC_STEPS+1];
  always_ff @(posedge clk_i) begin
    if (en) begin
      pt_q[0] <= {cz, cy, cx};
      for (int k = 1; k <= CORDIC_STEPS; k++) begin
        pt_q[k] <= pt_q[k-1];
      end
    end
  end

  logic signed [31:0] lyaw, lpit;
  laar_atan2 #(.STEPS(CORDIC_STEPS)) u_yaw (
    .clk_i (clk_i), .en_i (en), .z_i (cz), .s_i (cx), .ang_o (lyaw)
  );
  laar_atan2 #(.STEPS(CORDIC_STEPS)) u_pit (
    .clk_i (clk_i), .en_i (en), .z_i (cz), .s_i (cy), .ang_o (lpit)
  );

  // Output stage: saturated differences.
  function automatic logic [31:0] sat_sub(input logic [31:0] a, input logic [31:0] b);
    logic signed [32:0] d;
    d = 33'(signed'(a)) - 33'(signed'(b));
    if (d > 33'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end else if (d < -33'sd2147483648) begin
      return 32'h8000_0000;
    end
    return d[31:0];
  endfunction

  logic [183:0] out_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= {pt_q[CORDIC_STEPS],
                sat_sub(pit_q[LAT-2], lpit),
                sat_sub(yaw_q[LAT-2], lyaw)};
    end
  end
  assign m_axis_tdata = out_q;

endmodule

@@ rtl/core/laar_checker.sv @@
// Port-level checker for the laser aim block, bound to the top level.
// Depends on laser_aim_angle_from_range_assert.svh.
`include "laser_aim_angle_from_range_assert.svh"
module laar_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [183:0] m_axis_tdata
);

  // A stalled result holds its value.
  `LAAR_ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
  // Input is taken whenever output is free.
  `LAAR_ASSERT_IMP(a_rdy, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready)
  // Input stalls only behind a stalled output.
  `LAAR_ASSERT_IMP(a_stall, clk_i, rst_ni, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

endmodule

bind laser_aim_angle_from_range laar_checker u_chk (
  .clk_i (clk_i), .rst_ni (rst_ni),
  .s_axis_tvalid (s_axis_tvalid), .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid), .m_axis_tready (m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
